### rtl/core/tgb_pkg.sv
// Shared types and constants for the triangle tangent/bitangent block.
// No dependencies; every other file of the block refers to it by scoped names.
package tgb_pkg;

  localparam int unsigned OUT_WIDTH = 32;
  localparam int unsigned FRAC_OUT  = 16;
  // The divider develops one guard bit beyond the output fraction for rounding.
  localparam int unsigned QUO_FRAC  = FRAC_OUT + 1;
  // A quotient at or above 2^QUO_WIDTH is certain to clip.
  localparam int unsigned QUO_WIDTH = 34;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

### rtl/core/tgb_if.sv
// Channel interfaces for the vertex requests and the per-corner results.
// Depends on tgb_pkg for the output width.
interface tgb_vtx_if #(
  parameter int unsigned POS_WIDTH = 24,
  parameter int unsigned TEX_WIDTH = 18
);
  logic                        valid;
  logic                        ready;
  logic signed [POS_WIDTH-1:0] pos_x;
  logic signed [POS_WIDTH-1:0] pos_y;
  logic signed [POS_WIDTH-1:0] pos_z;
  logic signed [TEX_WIDTH-1:0] tex_u;
  logic signed [TEX_WIDTH-1:0] tex_v;
  logic                        mesh_start;

  modport source (output valid, pos_x, pos_y, pos_z, tex_u, tex_v, mesh_start,
                  input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, tex_u, tex_v, mesh_start,
                  output ready);
endinterface

interface tgb_res_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [tgb_pkg::OUT_WIDTH-1:0]  tangent_x;
  logic signed [tgb_pkg::OUT_WIDTH-1:0]  tangent_y;
  logic signed [tgb_pkg::OUT_WIDTH-1:0]  tangent_z;
  logic signed [tgb_pkg::OUT_WIDTH-1:0]  bitangent_x;
  logic signed [tgb_pkg::OUT_WIDTH-1:0]  bitangent_y;
  logic signed [tgb_pkg::OUT_WIDTH-1:0]  bitangent_z;
  logic                                  degenerate;
  logic                                  saturated;
  logic                                  last_copy;

  modport source (output valid, tangent_x, tangent_y, tangent_z, bitangent_x,
                  bitangent_y, bitangent_z, degenerate, saturated, last_copy,
                  input ready);
  modport sink   (input valid, tangent_x, tangent_y, tangent_z, bitangent_x,
                  bitangent_y, bitangent_z, degenerate, saturated, last_copy,
                  output ready);
endinterface

### rtl/core/tgb_front.sv
// Front end: groups vertices into triangles and forms the edge vectors.
// Depends on tgb_pkg and tgb_vtx_if.
module tgb_front #(
  parameter int unsigned POS_WIDTH = 24,
  parameter int unsigned TEX_WIDTH = 18,
  parameter int unsigned JOB_WIDTH = 6 * (POS_WIDTH + 1) + 4 * (TEX_WIDTH + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  tgb_vtx_if.sink               vtx,
  input  tgb_pkg::q_stat_t      q_stat_i,
  output logic                  push_o,
  output logic [JOB_WIDTH-1:0]  job_o
);

  localparam int unsigned EP = POS_WIDTH + 1;
  localparam int unsigned ET = TEX_WIDTH + 1;

  logic [1:0] phase_q, phase_d;
  logic [1:0] eff_phase;
  logic       accept;
  logic       is_third;

  logic signed [POS_WIDTH-1:0] cpx_q [2];
  logic signed [POS_WIDTH-1:0] cpy_q [2];
  logic signed [POS_WIDTH-1:0] cpz_q [2];
  logic signed [TEX_WIDTH-1:0] ctu_q [2];
  logic signed [TEX_WIDTH-1:0] ctv_q [2];

  logic signed [EP-1:0] d1x, d1y, d1z, d2x, d2y, d2z;
  logic signed [ET-1:0] du1, dv1, du2, dv2;

  // A mesh start, or the unused phase code, restarts on the first corner.
  always_comb begin
    if (vtx.mesh_start || phase_q == 2'd3) begin
      eff_phase = 2'd0;
    end else begin
      eff_phase = phase_q;
    end
  end

  assign is_third  = (eff_phase == 2'd2);
  assign vtx.ready = !is_third || !q_stat_i.full;
  assign accept    = vtx.valid && vtx.ready;
  assign push_o    = accept && is_third;

  assign d1x = EP'(cpx_q[1]) - EP'(cpx_q[0]);
  assign d1y = EP'(cpy_q[1]) - EP'(cpy_q[0]);
  assign d1z = EP'(cpz_q[1]) - EP'(cpz_q[0]);
  assign d2x = EP'(vtx.pos_x) - EP'(cpx_q[0]);
  assign d2y = EP'(vtx.pos_y) - EP'(cpy_q[0]);
  assign d2z = EP'(vtx.pos_z) - EP'(cpz_q[0]);
  assign du1 = ET'(ctu_q[1]) - ET'(ctu_q[0]);
  assign dv1 = ET'(ctv_q[1]) - ET'(ctv_q[0]);
  assign du2 = ET'(vtx.tex_u) - ET'(ctu_q[0]);
  assign dv2 = ET'(vtx.tex_v) - ET'(ctv_q[0]);

  assign job_o = {d1x, d1y, d1z, d2x, d2y, d2z, du1, dv1, du2, dv2};

  always_comb begin
    phase_d = phase_q;
    if (accept) begin
      phase_d = is_third ? 2'd0 : eff_phase + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 2'd0;
      for (int i = 0; i < 2; i++) begin
        cpx_q[i] <= '0;
        cpy_q[i] <= '0;
        cpz_q[i] <= '0;
        ctu_q[i] <= '0;
        ctv_q[i] <= '0;
      end
    end else begin
      phase_q <= phase_d;
      if (accept && !is_third) begin
        cpx_q[eff_phase[0]] <= vtx.pos_x;
        cpy_q[eff_phase[0]] <= vtx.pos_y;
        cpz_q[eff_phase[0]] <= vtx.pos_z;
        ctu_q[eff_phase[0]] <= vtx.tex_u;
        ctv_q[eff_phase[0]] <= vtx.tex_v;
      end
    end
  end

endmodule

### rtl/core/tgb_queue.sv
// Two-entry triangle queue between the front and back ends.
// Depends on tgb_pkg for the status struct.
module tgb_queue #(
  parameter int unsigned JOB_WIDTH = 190
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  logic [JOB_WIDTH-1:0]  job_i,
  input  logic                  pop_i,
  output logic [JOB_WIDTH-1:0]  job_o,
  output tgb_pkg::q_stat_t      stat_o
);

  logic [JOB_WIDTH-1:0] mem_q [2];
  logic                 wr_q, rd_q;
  logic [1:0]           cnt_q;

  assign stat_o.full  = (cnt_q == 2'd2);
  assign stat_o.empty = (cnt_q == 2'd0);
  assign job_o        = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= !wr_q;
      end
      if (pop_i) begin
        rd_q <= !rd_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

### rtl/core/tgb_back.sv
// Back end: determinant, six numerators, a bit-serial divider and result emission.
// Depends on tgb_pkg and tgb_res_if.
module tgb_back #(
  parameter int unsigned POS_WIDTH = 24,
  parameter int unsigned TEX_WIDTH = 18,
  parameter int unsigned JOB_WIDTH = 6 * (POS_WIDTH + 1) + 4 * (TEX_WIDTH + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [JOB_WIDTH-1:0]  job_i,
  input  tgb_pkg::q_stat_t      q_stat_i,
  output logic                  pop_o,
  tgb_res_if.source             res
);

  localparam int unsigned EP   = POS_WIDTH + 1;
  localparam int unsigned ET   = TEX_WIDTH + 1;
  localparam int unsigned AW   = (EP > ET) ? EP : ET;
  localparam int unsigned PW   = AW + ET;
  localparam int unsigned NUMW = PW + 1;
  localparam int unsigned NW   = NUMW + tgb_pkg::QUO_FRAC;
  localparam int unsigned CW   = $clog2(NW);
  localparam int unsigned OW   = tgb_pkg::OUT_WIDTH;
  localparam int unsigned QW   = tgb_pkg::QUO_WIDTH;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_DET_MUL = 3'd1;
  localparam logic [2:0] S_DET_SUB = 3'd2;
  localparam logic [2:0] S_NUM_MUL = 3'd3;
  localparam logic [2:0] S_NUM_SUB = 3'd4;
  localparam logic [2:0] S_DIV     = 3'd5;
  localparam logic [2:0] S_FIN     = 3'd6;
  localparam logic [2:0] S_EMIT    = 3'd7;

  logic [2:0] state_q, state_d;

  logic [JOB_WIDTH-1:0] job_q;
  logic signed [EP-1:0] d1x, d1y, d1z, d2x, d2y, d2z;
  logic signed [ET-1:0] du1, dv1, du2, dv2;

  logic signed [AW-1:0]   a0, a1;
  logic signed [ET-1:0]   b0, b1;
  logic signed [EP-1:0]   e1, e2;
  logic signed [PW-1:0]   p0_q, p1_q;
  logic signed [NUMW-1:0] diff;
  logic [NUMW-1:0]        diff_mag;
  logic [NUMW-1:0]        dmag_q;
  logic                   dneg_q;
  logic [2:0]             comp_q;
  logic [1:0]             sel;
  logic [NW-1:0]          dvd_q;
  logic [NUMW-1:0]        rem_q;
  logic [NUMW:0]          rem_sh;
  logic                   ge;
  logic [QW-1:0]          quo_q;
  logic                   ovf_q;
  logic [CW-1:0]          cnt_q;
  logic                   neg_q;
  logic [QW-1:0]          m_round, lim, m_clip;
  logic                   clip;
  logic signed [OW-1:0]   res_q [6];
  logic                   sat_q, degen_q;
  logic [1:0]             copy_q;
  logic                   out_free;

  assign {d1x, d1y, d1z, d2x, d2y, d2z, du1, dv1, du2, dv2} = job_q;

  assign pop_o    = (state_q == S_IDLE) && !q_stat_i.empty;
  assign out_free = !res.valid || res.ready;

  // Operand selection for the shared pair of multipliers.
  always_comb begin
    sel = (comp_q >= 3'd3) ? 2'(comp_q - 3'd3) : comp_q[1:0];
    unique case (sel)
      2'd0:    begin e1 = d1x; e2 = d2x; end
      2'd1:    begin e1 = d1y; e2 = d2y; end
      default: begin e1 = d1z; e2 = d2z; end
    endcase
    if (state_q == S_DET_MUL) begin
      a0 = AW'(du1); b0 = dv2;
      a1 = AW'(dv1); b1 = du2;
    end else if (comp_q < 3'd3) begin
      a0 = AW'(e1); b0 = dv2;
      a1 = AW'(e2); b1 = dv1;
    end else begin
      a0 = AW'(e2); b0 = du1;
      a1 = AW'(e1); b1 = du2;
    end
  end

  assign diff     = NUMW'(p0_q) - NUMW'(p1_q);
  assign diff_mag = diff[NUMW-1] ? NUMW'(-diff) : NUMW'(diff);

  assign rem_sh = {rem_q, dvd_q[NW-1]};
  assign ge     = (rem_sh >= {1'b0, dmag_q});

  // Round half away from zero on the magnitude, then clip to the signed range.
  assign m_round = QW'(({1'b0, quo_q} + {{QW{1'b0}}, 1'b1}) >> 1);
  assign lim     = neg_q ? (QW'(1) << (OW - 1)) : ((QW'(1) << (OW - 1)) - QW'(1));
  assign clip    = ovf_q || (m_round > lim);
  assign m_clip  = clip ? lim : m_round;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:    if (!q_stat_i.empty) state_d = S_DET_MUL;
      S_DET_MUL: state_d = S_DET_SUB;
      S_DET_SUB: state_d = (diff == '0) ? S_EMIT : S_NUM_MUL;
      S_NUM_MUL: state_d = S_NUM_SUB;
      S_NUM_SUB: state_d = S_DIV;
      S_DIV:     if (cnt_q == CW'(NW - 1)) state_d = S_FIN;
      S_FIN:     state_d = (comp_q == 3'd5) ? S_EMIT : S_NUM_MUL;
      S_EMIT:    if (out_free && copy_q == 2'd2) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= job_i;
    end
    if (state_q == S_DET_MUL || state_q == S_NUM_MUL) begin
      p0_q <= a0 * b0;
      p1_q <= a1 * b1;
    end
    if (state_q == S_DET_SUB) begin
      dmag_q <= diff_mag;
      dneg_q <= diff[NUMW-1];
    end
    if (state_q == S_NUM_SUB) begin
      dvd_q <= {diff_mag, {tgb_pkg::QUO_FRAC{1'b0}}};
      rem_q <= '0;
      quo_q <= '0;
      ovf_q <= 1'b0;
      cnt_q <= '0;
      neg_q <= diff[NUMW-1] ^ dneg_q;
    end
    if (state_q == S_DIV) begin
      dvd_q <= dvd_q << 1;
      rem_q <= ge ? NUMW'(rem_sh - {1'b0, dmag_q}) : rem_sh[NUMW-1:0];
      quo_q <= {quo_q[QW-2:0], ge};
      ovf_q <= ovf_q | quo_q[QW-1];
      cnt_q <= cnt_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      comp_q    <= 3'd0;
      copy_q    <= 2'd0;
      sat_q     <= 1'b0;
      degen_q   <= 1'b0;
      res.valid <= 1'b0;
      for (int i = 0; i < 6; i++) begin
        res_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (state_q == S_DET_SUB) begin
        comp_q  <= 3'd0;
        copy_q  <= 2'd0;
        sat_q   <= 1'b0;
        degen_q <= (diff == '0);
        for (int i = 0; i < 6; i++) begin
          res_q[i] <= '0;
        end
      end
      if (state_q == S_FIN) begin
        res_q[comp_q] <= neg_q ? OW'(-m_clip) : OW'(m_clip);
        sat_q         <= sat_q | clip;
        comp_q        <= comp_q + 3'd1;
      end
      if (state_q == S_EMIT && out_free) begin
        res.valid <= 1'b1;
        copy_q    <= copy_q + 2'd1;
      end else if (res.valid && res.ready) begin
        res.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_EMIT && out_free) begin
      res.tangent_x   <= res_q[0];
      res.tangent_y   <= res_q[1];
      res.tangent_z   <= res_q[2];
      res.bitangent_x <= res_q[3];
      res.bitangent_y <= res_q[4];
      res.bitangent_z <= res_q[5];
      res.degenerate  <= degen_q;
      res.saturated   <= sat_q;
      res.last_copy   <= (copy_q == 2'd2);
    end
  end

endmodule

### rtl/core/triangle_tangent_basis.sv
// Top level of the per-triangle tangent and bitangent unit.
// Depends on tgb_pkg, tgb_if, tgb_front, tgb_queue and tgb_back.
//
//   channel  dir  handshake        request
//   vtx      in   valid / ready    one vertex: position, texture coordinate, mesh start
//   res      out  valid / ready    one corner copy of the tangent and bitangent
//
// The front end takes one vertex per cycle. The first two corners of a triangle are
// stored; the third forms all edges and enters a two-entry queue, and stalls only
// while that queue is full. The back end works on numerators of NUMW bits,
// NUMW = max(POS_WIDTH, TEX_WIDTH) + TEX_WIDTH + 3; its bit-serial divider develops
// one quotient bit per cycle, six quotients per triangle. A zero determinant skips
// the divider. Reset clears the corner store and the phase; a stalled result holds
// in the output register.
module triangle_tangent_basis #(
  parameter int unsigned POS_WIDTH = 24,
  parameter int unsigned TEX_WIDTH = 18
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  tgb_vtx_if.sink vtx,
  tgb_res_if.source res
);

  localparam int unsigned JOB_WIDTH = 6 * (POS_WIDTH + 1) + 4 * (TEX_WIDTH + 1);

  logic                  push;
  logic                  pop;
  logic [JOB_WIDTH-1:0]  job_in;
  logic [JOB_WIDTH-1:0]  job_out;
  tgb_pkg::q_stat_t      q_stat;

  // Vertex grouping and edge formation.
  tgb_front #(
    .POS_WIDTH (POS_WIDTH),
    .TEX_WIDTH (TEX_WIDTH),
    .JOB_WIDTH (JOB_WIDTH)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .vtx      (vtx),
    .q_stat_i (q_stat),
    .push_o   (push),
    .job_o    (job_in)
  );

  // Decouples vertex intake from the long division sequence.
  tgb_queue #(
    .JOB_WIDTH (JOB_WIDTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (job_in),
    .pop_i  (pop),
    .job_o  (job_out),
    .stat_o (q_stat)
  );

  // Determinant, numerators, division and the three result copies.
  tgb_back #(
    .POS_WIDTH (POS_WIDTH),
    .TEX_WIDTH (TEX_WIDTH),
    .JOB_WIDTH (JOB_WIDTH)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .job_i    (job_out),
    .q_stat_i (q_stat),
    .pop_o    (pop),
    .res      (res)
  );

`ifndef SYNTHESIS
  // A degenerate triangle always carries zero vectors.
  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res.valid && res.degenerate) |-> (res.tangent_x == '0 && res.bitangent_z == '0))
    else $error("degenerate result with nonzero vector");

  // Degenerate results never report clipping.
  a_degen_nosat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res.valid && res.degenerate) |-> !res.saturated)
    else $error("degenerate result flagged saturated");

  // The front end never pushes into a full queue.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_stat.full)
    else $error("triangle queue overflow");

  // The back end only pops when a triangle is waiting.
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_stat.empty)
    else $error("triangle queue underflow");
`endif

endmodule

### dv/testbench.sv
// Self-checking testbench for triangle_tangent_basis: vertex requests in, corner results out.
// Depends on tgb_pkg, the tgb_vtx_if and tgb_res_if interfaces and the block's RTL.
module testbench;

  localparam int unsigned POS_W = 24;
  localparam int unsigned TEX_W = 18;
  // Back end cost of one triangle at these widths, plus margin for the queue.
  localparam int unsigned TRI_CYCLES = 400;

  typedef struct {
    logic signed [POS_W-1:0] px, py, pz;
    logic signed [TEX_W-1:0] u, v;
    logic                    ms;
    bit                      drain;  // hold this request until all results are in
  } vertex_t;

  typedef struct {
    logic signed [tgb_pkg::OUT_WIDTH-1:0] t[3];
    logic signed [tgb_pkg::OUT_WIDTH-1:0] b[3];
    logic                                 degen, sat, last;
  } corner_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  tgb_vtx_if #(.POS_WIDTH(POS_W), .TEX_WIDTH(TEX_W)) vtx ();
  tgb_res_if res ();

  triangle_tangent_basis #(.POS_WIDTH(POS_W), .TEX_WIDTH(TEX_W)) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .vtx   (vtx.sink),
    .res   (res.source)
  );

  vertex_t     vertex_q[$];
  corner_res_t basis_q[$];
  vertex_t     nx_cur;
  int          n_errors = 0;
  int          n_sent = 0;
  int          n_results = 0;
  int          n_triangles = 0;
  int          n_degen = 0;
  int          n_sat = 0;
  bit          stim_done = 1'b0;

  // Own copy of the corner store and phase.
  longint      cpx[2], cpy[2], cpz[2], cu[2], cv[2];
  int unsigned phase = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Quotient num * 2^16 / den, rounded half away from zero, clipped to 32 bits.
  function automatic longint basis_div(longint num, longint den, ref bit sat);
    longint unsigned n, d, lim, m;
    bit neg;
    n = (num < 0) ? -num : num;
    d = (den < 0) ? -den : den;
    neg = (num < 0) != (den < 0);
    lim = neg ? 64'd2147483648 : 64'd2147483647;
    if (n == 0) return 0;
    if (n / d > lim) begin
      m = lim;
      sat = 1'b1;
    end else begin
      // n stays below 2^46, so the shift cannot overflow.
      m = (((n << (tgb_pkg::FRAC_OUT + 1)) / d) + 1) >> 1;
      if (m > lim) begin
        m = lim;
        sat = 1'b1;
      end
    end
    return neg ? -longint'(m) : longint'(m);
  endfunction

  // Advance the corner state by one accepted vertex and queue any expected copies.
  task automatic predict_corner(vertex_t vx);
    longint d1[3], d2[3], du1, dv1, du2, dv2, det, num;
    longint p[3];
    longint r[6];
    bit sat;
    corner_res_t e;
    int unsigned ph;
    ph = vx.ms ? 0 : phase;
    if (ph == 3) ph = 0;
    if (ph < 2) begin
      cpx[ph] = vx.px; cpy[ph] = vx.py; cpz[ph] = vx.pz;
      cu[ph] = vx.u; cv[ph] = vx.v;
      phase = ph + 1;
      return;
    end
    phase = 0;
    p[0] = vx.px; p[1] = vx.py; p[2] = vx.pz;
    d1[0] = cpx[1] - cpx[0]; d1[1] = cpy[1] - cpy[0]; d1[2] = cpz[1] - cpz[0];
    d2[0] = p[0] - cpx[0];   d2[1] = p[1] - cpy[0];   d2[2] = p[2] - cpz[0];
    du1 = cu[1] - cu[0];
    dv1 = cv[1] - cv[0];
    du2 = longint'(vx.u) - cu[0];
    dv2 = longint'(vx.v) - cv[0];
    det = du1 * dv2 - dv1 * du2;
    sat = 1'b0;
    foreach (r[j]) r[j] = 0;
    if (det != 0) begin
      for (int j = 0; j < 3; j++) begin
        num = d1[j] * dv2 - d2[j] * dv1;
        r[j] = basis_div(num, det, sat);
        num = d2[j] * du1 - d1[j] * du2;
        r[3 + j] = basis_div(num, det, sat);
      end
    end
    n_triangles++;
    if (det == 0) n_degen++;
    if (sat) n_sat++;
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < 3; j++) begin
        e.t[j] = r[j][31:0];
        e.b[j] = r[3 + j][31:0];
      end
      e.degen = (det == 0);
      e.sat = sat;
      e.last = (k == 2);
      basis_q = {basis_q, e};
    end
  endtask

  task automatic add_vertex(longint px, longint py, longint pz, longint u, longint v,
                            bit ms, bit drain = 1'b0);
    vertex_t vx;
    vx.px = px[POS_W-1:0]; vx.py = py[POS_W-1:0]; vx.pz = pz[POS_W-1:0];
    vx.u = u[TEX_W-1:0]; vx.v = v[TEX_W-1:0];
    vx.ms = ms;
    vx.drain = drain;
    vertex_q = {vertex_q, vx};
  endtask

  function automatic longint rand_pos();
    return longint'($signed($urandom_range(0, (1 << POS_W) - 1) << (32 - POS_W))) >>>
           (32 - POS_W);
  endfunction

  function automatic longint rand_tex();
    return longint'($signed($urandom_range(0, (1 << TEX_W) - 1) << (32 - TEX_W))) >>>
           (32 - TEX_W);
  endfunction

  // One random triangle. The texture corners are either spread over the full range,
  // clustered to give a tiny determinant (and likely clipping), or collinear.
  task automatic add_random_triangle();
    longint u0, v0, u1, v1, u2, v2;
    int unsigned mode;
    bit ms;
    mode = $urandom_range(0, 9);
    u0 = rand_tex();
    v0 = rand_tex();
    if (mode < 6) begin
      u1 = rand_tex(); v1 = rand_tex(); u2 = rand_tex(); v2 = rand_tex();
    end else if (mode < 9) begin
      u1 = u0 + $urandom_range(0, 6) - 3; v1 = v0 + $urandom_range(0, 6) - 3;
      u2 = u0 + $urandom_range(0, 6) - 3; v2 = v0 + $urandom_range(0, 6) - 3;
    end else begin
      u1 = u0; v1 = v0; u2 = rand_tex(); v2 = rand_tex();
    end
    ms = $urandom_range(0, 1);
    add_vertex(rand_pos(), rand_pos(), rand_pos(), u0, v0, ms);
    add_vertex(rand_pos(), rand_pos(), rand_pos(), u1, v1, 1'b0);
    add_vertex(rand_pos(), rand_pos(), rand_pos(), u2, v2, 1'b0);
  endtask

  // Request driver: presents the next pending vertex and predicts on acceptance.
  always @(posedge clk_i) begin
    vertex_t nx;
    bit      fire, idle, hold;
    if (rst_ni) begin
      fire = vtx.valid && vtx.ready;
      if (fire) begin
        predict_corner(nx_cur);
        n_sent++;
      end
      if (!vtx.valid || fire) begin
        // Requests 40 to 80 go out back to back.
        idle = (n_sent < 40 || n_sent > 80) && ($urandom_range(0, 99) < 34);
        hold = vertex_q.size() > 0 && vertex_q[0].drain && basis_q.size() > 0;
        if (vertex_q.size() > 0 && !idle && !hold) begin
          nx = vertex_q.pop_front();
          nx_cur <= nx;
          vtx.valid <= 1'b1;
          vtx.pos_x <= nx.px; vtx.pos_y <= nx.py; vtx.pos_z <= nx.pz;
          vtx.tex_u <= nx.u; vtx.tex_v <= nx.v;
          vtx.mesh_start <= nx.ms;
        end else begin
          vtx.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: random back-pressure and a field-by-field check of each copy.
  always @(posedge clk_i) begin
    corner_res_t e;
    if (rst_ni) begin
      if (res.valid && res.ready) begin
        n_results++;
        if (basis_q.size() == 0) begin
          $error("result with no expectation pending");
          n_errors++;
        end else begin
          e = basis_q.pop_front();
          if (res.tangent_x !== e.t[0]) begin
            $error("tangent_x: expected %0d, got %0d", e.t[0], res.tangent_x);
            n_errors++;
          end
          if (res.tangent_y !== e.t[1]) begin
            $error("tangent_y: expected %0d, got %0d", e.t[1], res.tangent_y);
            n_errors++;
          end
          if (res.tangent_z !== e.t[2]) begin
            $error("tangent_z: expected %0d, got %0d", e.t[2], res.tangent_z);
            n_errors++;
          end
          if (res.bitangent_x !== e.b[0]) begin
            $error("bitangent_x: expected %0d, got %0d", e.b[0], res.bitangent_x);
            n_errors++;
          end
          if (res.bitangent_y !== e.b[1]) begin
            $error("bitangent_y: expected %0d, got %0d", e.b[1], res.bitangent_y);
            n_errors++;
          end
          if (res.bitangent_z !== e.b[2]) begin
            $error("bitangent_z: expected %0d, got %0d", e.b[2], res.bitangent_z);
            n_errors++;
          end
          if (res.degenerate !== e.degen) begin
            $error("degenerate: expected %0b, got %0b", e.degen, res.degenerate);
            n_errors++;
          end
          if (res.saturated !== e.sat) begin
            $error("saturated: expected %0b, got %0b", e.sat, res.saturated);
            n_errors++;
          end
          if (res.last_copy !== e.last) begin
            $error("last_copy: expected %0b, got %0b", e.last, res.last_copy);
            n_errors++;
          end
        end
      end
      // Results 30 to 60 are taken without any stall.
      res.ready <= (n_results >= 30 && n_results <= 60) || ($urandom_range(0, 99) >= 34);
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    vtx.valid = 1'b0;
    vtx.pos_x = '0; vtx.pos_y = '0; vtx.pos_z = '0;
    vtx.tex_u = '0; vtx.tex_v = '0;
    vtx.mesh_start = 1'b0;
    res.ready = 1'b0;

    // Plain triangle straight after reset, relying on the reset phase.
    add_vertex(0, 0, 0, 0, 0, 1'b0);
    add_vertex(65536, 0, 0, 65536, 0, 1'b0);
    add_vertex(0, 65536, 0, 0, 65536, 1'b0);
    // Position and texture extremes.
    add_vertex(8388607, -8388608, 8388607, -131072, -131072, 1'b1);
    add_vertex(-8388608, 8388607, -8388608, 131071, -131072, 1'b0);
    add_vertex(8388607, 8388607, -8388608, -131072, 131071, 1'b0);
    // Zero determinant: all corners share one texture coordinate.
    add_vertex(100, 200, 300, 5000, -7000, 1'b1);
    add_vertex(-400, 500, 600, 5000, -7000, 1'b0);
    add_vertex(700, -800, 900, 5000, -7000, 1'b0);
    // Determinant of one with large edges clips every component but the zero bitangent_y.
    add_vertex(-8388608, -8388608, -8388608, 0, 0, 1'b1);
    add_vertex(8388607, 8388607, 8388607, 1, 0, 1'b0);
    add_vertex(8388607, -8388608, 8388607, 0, 1, 1'b0);
    // Partial triangle abandoned by a mesh start at the second and the third corner.
    add_vertex(1, 2, 3, 4, 5, 1'b1);
    add_vertex(6, 7, 8, 9, 10, 1'b1);
    add_vertex(11, 12, 13, 14, 15, 1'b0);
    add_vertex(-20, 30, -40, 1000, -2000, 1'b1);
    add_vertex(500, -600, 700, -3000, 4000, 1'b0);
    add_vertex(-9000, 8000, 7000, 6000, 5000, 1'b0);
    // Next triangle follows without a mesh start; the sender first waits for all
    // results so far to drain.
    add_vertex(1, -1, 1, 3, -3, 1'b0, 1'b1);
    add_vertex(123456, -654321, 4242, -99999, 77777, 1'b0);
    add_vertex(-314159, 271828, -161803, 12345, -54321, 1'b0);

    for (int i = 0; i < 28; i++) begin
      if ($urandom_range(0, 7) == 0) begin
        // Stray vertices that leave a partial triangle behind.
        repeat ($urandom_range(1, 2))
          add_vertex(rand_pos(), rand_pos(), rand_pos(), rand_tex(), rand_tex(),
                     $urandom_range(0, 1));
      end
      add_random_triangle();
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (vertex_q.size() == 0);
    @(posedge clk_i iff !vtx.valid);
    wait (basis_q.size() == 0);
    repeat (2 * TRI_CYCLES) @(posedge clk_i);

    $display("Sent %0d vertices forming %0d triangles; checked %0d corner results.",
             n_sent, n_triangles, n_results);
    $display("%0d triangles were degenerate and %0d clipped.", n_degen, n_sat);
    if (n_errors == 0 && basis_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("tb: failure");
    $finish;
  end

endmodule

### sim.f
rtl/core/tgb_pkg.sv
rtl/core/tgb_if.sv
rtl/core/tgb_front.sv
rtl/core/tgb_queue.sv
rtl/core/tgb_back.sv
rtl/core/triangle_tangent_basis.sv
dv/testbench.sv
